[sv/fec_pkg.sv]
// Shared types and constants for the frame ethertype classifier.
package fec_pkg;

    localparam logic [3:0] CLS_NONE    = 4'd0;
    localparam logic [3:0] CLS_DHCP    = 4'd1;
    localparam logic [3:0] CLS_ND      = 4'd2;
    localparam logic [3:0] CLS_DHCPV6  = 4'd3;
    localparam logic [3:0] CLS_EAPOL   = 4'd4;
    localparam logic [3:0] CLS_TDLS    = 4'd5;
    localparam logic [3:0] CLS_PPPOE   = 4'd6;
    localparam logic [3:0] CLS_WAPI    = 4'd7;
    localparam logic [3:0] CLS_VLAN    = 4'd8;
    localparam logic [3:0] CLS_ARP_REQ = 4'd9;
    localparam logic [3:0] CLS_ARP_RSP = 4'd10;

    localparam logic [15:0] ET_IPV4      = 16'h0800;
    localparam logic [15:0] ET_IPV6      = 16'h86DD;
    localparam logic [15:0] ET_ARP       = 16'h0806;
    localparam logic [15:0] ET_EAPOL     = 16'h888E;
    localparam logic [15:0] ET_TDLS      = 16'h890D;
    localparam logic [15:0] ET_PPPOE_D   = 16'h8863;
    localparam logic [15:0] ET_PPPOE_S   = 16'h8864;
    localparam logic [15:0] ET_WAPI      = 16'h88B4;
    localparam logic [15:0] ET_VLAN      = 16'h8100;
    localparam logic [15:0] ET_QINQ      = 16'h88A8;
    localparam logic [15:0] ET_QINQ_OLD  = 16'h9100;

    localparam logic [5:0] ETH_TYPE_OFF  = 6'd12;
    localparam logic [5:0] SNAP_TYPE_OFF = 6'd6;
    localparam logic [5:0] OFF_MAX       = 6'd63;

    localparam logic [5:0] V4_FRAG_HI = 6'd6;
    localparam logic [5:0] V4_FRAG_LO = 6'd7;
    localparam logic [5:0] V4_PROTO   = 6'd9;
    localparam logic [5:0] V4_PORT_HI = 6'd22;
    localparam logic [5:0] V4_PORT_LO = 6'd23;
    localparam logic [5:0] V6_NEXT    = 6'd6;
    localparam logic [5:0] V6_ICMP    = 6'd40;
    localparam logic [5:0] V6_PORT_HI = 6'd42;
    localparam logic [5:0] V6_PORT_LO = 6'd43;
    localparam logic [5:0] ARP_OP_HI  = 6'd6;
    localparam logic [5:0] ARP_OP_LO  = 6'd7;

    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;
    localparam logic [7:0]  ND_TYPE_LOW  = 8'd133;
    localparam logic [7:0]  ND_TYPE_HIGH = 8'd137;
    localparam logic [15:0] FRAG_MASK    = 16'h1FFF;
    localparam logic [15:0] PORT_BOOTPS  = 16'd67;
    localparam logic [15:0] PORT_BOOTPC  = 16'd68;
    localparam logic [15:0] PORT_DHCP6C  = 16'd546;
    localparam logic [15:0] PORT_DHCP6S  = 16'd547;
    localparam logic [15:0] ARP_OP_REQ   = 16'd1;
    localparam logic [15:0] ARP_OP_RSP   = 16'd2;

    localparam int FL_TYPE  = 0;
    localparam int FL_PROTO = 1;
    localparam int FL_AUX   = 2;
    localparam int FL_PORT  = 3;

    typedef struct packed {
        logic [3:0]  frame_class;
        logic [15:0] ether_type;
    } t_result;

endpackage

[sv/fec_front.sv]
// Front end: tracks the byte offset, captures header fields and classifies each frame.
module fec_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_byte,
    input  logic              i_last_byte,
    input  logic              i_header_is_snap,
    output fec_pkg::t_result  o_result
);

    logic [5:0]  r_offset, n_offset;
    logic        r_snap, n_snap;
    logic [15:0] r_type, n_type;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_frag, n_frag;
    logic [15:0] r_port, n_port;
    logic [7:0]  r_icmp, n_icmp;
    logic [3:0]  r_flags, n_flags;

    logic [5:0]  eff_off;
    logic [5:0]  type_off;
    logic [5:0]  body_off;
    logic [5:0]  rel;
    logic [3:0]  cls;

    always_comb begin
        eff_off  = i_first_byte ? 6'd0 : r_offset;
        n_snap   = i_first_byte ? i_header_is_snap : r_snap;
        n_type   = i_first_byte ? 16'd0 : r_type;
        n_proto  = i_first_byte ? 8'd0 : r_proto;
        n_frag   = i_first_byte ? 16'd0 : r_frag;
        n_port   = i_first_byte ? 16'd0 : r_port;
        n_icmp   = i_first_byte ? 8'd0 : r_icmp;
        n_flags  = i_first_byte ? 4'd0 : r_flags;
        type_off = n_snap ? fec_pkg::SNAP_TYPE_OFF : fec_pkg::ETH_TYPE_OFF;
        body_off = type_off + 6'd2;
        rel      = eff_off - body_off;

        if (eff_off == type_off) begin
            n_type = {i_data_byte, 8'h00};
        end else if (eff_off == type_off + 6'd1) begin
            n_type = {n_type[15:8], i_data_byte};
            n_flags[fec_pkg::FL_TYPE] = 1'b1;
        end else if (eff_off >= body_off && n_flags[fec_pkg::FL_TYPE]) begin
            if (n_type == fec_pkg::ET_IPV4) begin
                case (rel)
                    fec_pkg::V4_FRAG_HI: n_frag = {i_data_byte, 8'h00};
                    fec_pkg::V4_FRAG_LO: begin
                        n_frag = {n_frag[15:8], i_data_byte};
                        n_flags[fec_pkg::FL_AUX] = 1'b1;
                    end
                    fec_pkg::V4_PROTO: begin
                        n_proto = i_data_byte;
                        n_flags[fec_pkg::FL_PROTO] = 1'b1;
                    end
                    fec_pkg::V4_PORT_HI: n_port = {i_data_byte, 8'h00};
                    fec_pkg::V4_PORT_LO: begin
                        n_port = {n_port[15:8], i_data_byte};
                        n_flags[fec_pkg::FL_PORT] = 1'b1;
                    end
                    default: ;
                endcase
            end else if (n_type == fec_pkg::ET_IPV6) begin
                case (rel)
                    fec_pkg::V6_NEXT: begin
                        n_proto = i_data_byte;
                        n_flags[fec_pkg::FL_PROTO] = 1'b1;
                    end
                    fec_pkg::V6_ICMP: begin
                        n_icmp = i_data_byte;
                        n_flags[fec_pkg::FL_AUX] = 1'b1;
                    end
                    fec_pkg::V6_PORT_HI: n_port = {i_data_byte, 8'h00};
                    fec_pkg::V6_PORT_LO: begin
                        n_port = {n_port[15:8], i_data_byte};
                        n_flags[fec_pkg::FL_PORT] = 1'b1;
                    end
                    default: ;
                endcase
            end else if (n_type == fec_pkg::ET_ARP) begin
                case (rel)
                    fec_pkg::ARP_OP_HI: n_port = {i_data_byte, 8'h00};
                    fec_pkg::ARP_OP_LO: begin
                        n_port = {n_port[15:8], i_data_byte};
                        n_flags[fec_pkg::FL_PORT] = 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        n_offset = (eff_off < fec_pkg::OFF_MAX) ? eff_off + 6'd1 : eff_off;
    end

    always_comb begin
        cls = fec_pkg::CLS_NONE;
        if (n_flags[fec_pkg::FL_TYPE]) begin
            case (n_type)
                fec_pkg::ET_IPV4: begin
                    if (n_flags[fec_pkg::FL_PROTO] && n_flags[fec_pkg::FL_AUX] &&
                        n_flags[fec_pkg::FL_PORT] && n_proto == fec_pkg::PROTO_UDP &&
                        (n_frag & fec_pkg::FRAG_MASK) == 16'd0 &&
                        (n_port == fec_pkg::PORT_BOOTPS || n_port == fec_pkg::PORT_BOOTPC)) begin
                        cls = fec_pkg::CLS_DHCP;
                    end
                end
                fec_pkg::ET_IPV6: begin
                    if (n_flags[fec_pkg::FL_PROTO] && n_flags[fec_pkg::FL_AUX] &&
                        n_proto == fec_pkg::PROTO_ICMPV6 &&
                        n_icmp inside {[fec_pkg::ND_TYPE_LOW:fec_pkg::ND_TYPE_HIGH]}) begin
                        cls = fec_pkg::CLS_ND;
                    end else if (n_flags[fec_pkg::FL_PROTO] && n_flags[fec_pkg::FL_PORT] &&
                        n_proto == fec_pkg::PROTO_UDP &&
                        (n_port == fec_pkg::PORT_DHCP6C || n_port == fec_pkg::PORT_DHCP6S)) begin
                        cls = fec_pkg::CLS_DHCPV6;
                    end
                end
                fec_pkg::ET_EAPOL: cls = fec_pkg::CLS_EAPOL;
                fec_pkg::ET_TDLS:  cls = fec_pkg::CLS_TDLS;
                fec_pkg::ET_PPPOE_D, fec_pkg::ET_PPPOE_S: cls = fec_pkg::CLS_PPPOE;
                fec_pkg::ET_WAPI:  cls = fec_pkg::CLS_WAPI;
                fec_pkg::ET_VLAN, fec_pkg::ET_QINQ, fec_pkg::ET_QINQ_OLD: begin
                    cls = fec_pkg::CLS_VLAN;
                end
                fec_pkg::ET_ARP: begin
                    if (n_flags[fec_pkg::FL_PORT] && n_port == fec_pkg::ARP_OP_REQ) begin
                        cls = fec_pkg::CLS_ARP_REQ;
                    end else if (n_flags[fec_pkg::FL_PORT] && n_port == fec_pkg::ARP_OP_RSP) begin
                        cls = fec_pkg::CLS_ARP_RSP;
                    end
                end
                default: cls = fec_pkg::CLS_NONE;
            endcase
        end
        o_result.frame_class = cls;
        o_result.ether_type  = n_flags[fec_pkg::FL_TYPE] ? n_type : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 6'd0;
            r_snap   <= 1'b0;
            r_type   <= 16'd0;
            r_proto  <= 8'd0;
            r_frag   <= 16'd0;
            r_port   <= 16'd0;
            r_icmp   <= 8'd0;
            r_flags  <= 4'd0;
        end else if (i_take) begin
            r_snap <= n_snap;
            if (i_last_byte) begin
                r_offset <= 6'd0;
                r_type   <= 16'd0;
                r_proto  <= 8'd0;
                r_frag   <= 16'd0;
                r_port   <= 16'd0;
                r_icmp   <= 8'd0;
                r_flags  <= 4'd0;
            end else begin
                r_offset <= n_offset;
                r_type   <= n_type;
                r_proto  <= n_proto;
                r_frag   <= n_frag;
                r_port   <= n_port;
                r_icmp   <= n_icmp;
                r_flags  <= n_flags;
            end
        end
    end

    // A frame that ends always leaves the next byte at offset zero with no captures.
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_last_byte) |=> (r_offset == 6'd0 && r_flags == 4'd0))
        else $error("frame state not cleared after last byte");

endmodule

[sv/fec_queue.sv]
// Two-entry queue of classified results between the front end and the output stage.
module fec_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fec_pkg::t_result  i_result,
    input  logic              i_pop,
    output fec_pkg::t_result  o_result,
    output logic              o_empty,
    output logic              o_full
);

    fec_pkg::t_result r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_result = r_mem[r_rd_ptr];
    assign o_empty  = (r_count == 2'd0);
    assign o_full   = (r_count == 2'd2);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("request popped from an empty queue");

    a_count_pointers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd3) && ((r_count == 2'd1) == (r_wr_ptr != r_rd_ptr)))
        else $error("queue count disagrees with its pointers");

endmodule

[sv/fec_back.sv]
// Output stage: pops classified results and holds each until the consumer takes it.
module fec_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fec_pkg::t_result  i_result,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_frame_class,
    output logic [15:0]       o_ether_type
);

    logic             r_valid;
    fec_pkg::t_result r_result;

    assign o_pop         = !i_empty && (!r_valid || i_ready);
    assign o_valid       = r_valid;
    assign o_frame_class = r_result.frame_class;
    assign o_ether_type  = r_result.ether_type;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

[sv/frame_ethertype_classifier.sv]
// Top level of the frame ethertype classifier: front end, result queue and output stage.
//
//   channel  direction  handshake             payload
//   in       input      i_valid / o_ready     i_data_byte, i_first_byte, i_last_byte,
//                                             i_header_is_snap
//   out      output     o_valid / i_ready     o_frame_class, o_ether_type
//
// A byte is taken each cycle o_ready is high; results are queued, then registered.
// The input stalls only when the two-entry result queue is full.
// Reset is synchronous and clears the frame state, the queue and the output register.
// A stalled output never blocks bytes that do not end a frame until the queue fills.
module frame_ethertype_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic        i_header_is_snap,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_frame_class,
    output logic [15:0] o_ether_type
);

    fec_pkg::t_result front_result;
    fec_pkg::t_result head_result;
    logic             take;
    logic             q_empty;
    logic             q_full;
    logic             q_pop;

    assign o_ready = !q_full;
    assign take    = i_valid && o_ready;

    fec_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_data_byte      (i_data_byte),
        .i_first_byte     (i_first_byte),
        .i_last_byte      (i_last_byte),
        .i_header_is_snap (i_header_is_snap),
        .o_result         (front_result)
    );

    fec_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (take && i_last_byte),
        .i_result (front_result),
        .i_pop    (q_pop),
        .o_result (head_result),
        .o_empty  (q_empty),
        .o_full   (q_full)
    );

    fec_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_result      (head_result),
        .i_empty       (q_empty),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_frame_class (o_frame_class),
        .o_ether_type  (o_ether_type)
    );

endmodule
